// ----- rtl/bdot_sunpoint_attitude_control_unit_defines.svh -----
// Assertion macros used by the checker file of the attitude control unit.
`ifndef BDOT_SUNPOINT_ATTITUDE_CONTROL_UNIT_DEFINES_SVH
`define BDOT_SUNPOINT_ATTITUDE_CONTROL_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BSAC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BSAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bsac_pkg.sv -----
// Types, constants and codes of the attitude control unit.
`default_nettype none
package bsac_pkg;

    localparam int FIELD_WIDTH_DEF  = 18;
    localparam int TORQUE_WIDTH_DEF = 32;
    localparam int APB_ADDR_W       = 4;

    localparam int ALU_W      = 64;
    localparam int CNT_W      = 7;
    localparam int MUL_STEPS  = 34;
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 24;
    localparam logic [ALU_W-1:0] SQRT_BIT0 = 64'd1 << 46;

    localparam logic [31:0] DETUMBLE_GAIN_RST = 32'd42950;
    localparam logic [31:0] SUN_GAIN_RST      = 32'd42950;
    localparam logic [15:0] RATE_THR_RST      = 16'd82;
    localparam logic [15:0] SUN_MIN_RST       = 16'd164;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctl_t;

    typedef enum logic [1:0] {
        REG_DETUMBLE_GAIN,
        REG_SUN_GAIN,
        REG_RATE_THR,
        REG_SUN_MIN
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] detumble_gain;
        logic [31:0] sun_gain;
        logic [15:0] rate_threshold;
        logic [15:0] sun_min_magnitude;
    } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/bsac_if.sv -----
// Request channel interfaces of the attitude control unit.
`default_nettype none
interface bsac_in_if #(
    parameter int FIELD_WIDTH = bsac_pkg::FIELD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [FIELD_WIDTH-1:0] field_x;
    logic signed [FIELD_WIDTH-1:0] field_y;
    logic signed [FIELD_WIDTH-1:0] field_z;
    logic signed [15:0]            sun_x;
    logic signed [15:0]            sun_y;
    logic signed [15:0]            sun_z;
    logic                          eclipse;
    logic signed [15:0]            rate_x;
    logic signed [15:0]            rate_y;
    logic signed [15:0]            rate_z;

    modport source (output valid, field_x, field_y, field_z, sun_x, sun_y, sun_z,
                    eclipse, rate_x, rate_y, rate_z, input ready);
    modport sink (input valid, field_x, field_y, field_z, sun_x, sun_y, sun_z,
                  eclipse, rate_x, rate_y, rate_z, output ready);
endinterface

interface bsac_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;
    logic               mode_now;

    modport source (output valid, torque_x, torque_y, torque_z, mode_now, input ready);
    modport sink (input valid, torque_x, torque_y, torque_z, mode_now, output ready);
endinterface
`default_nettype wire

// ----- rtl/bsac_regs.sv -----
// APB configuration registers of the attitude control unit.
`default_nettype none
module bsac_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bsac_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready,
    output bsac_pkg::cfg_t                        cfg
);
    import bsac_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write the addressed register on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detumble_gain     <= DETUMBLE_GAIN_RST;
            cfg_reg.sun_gain          <= SUN_GAIN_RST;
            cfg_reg.rate_threshold    <= RATE_THR_RST;
            cfg_reg.sun_min_magnitude <= SUN_MIN_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_DETUMBLE_GAIN: cfg_reg.detumble_gain     <= pwdata;
                REG_SUN_GAIN:      cfg_reg.sun_gain          <= pwdata;
                REG_RATE_THR:      cfg_reg.rate_threshold    <= pwdata[15:0];
                REG_SUN_MIN:       cfg_reg.sun_min_magnitude <= pwdata[15:0];
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        unique case (idx)
            REG_DETUMBLE_GAIN: prdata = cfg_reg.detumble_gain;
            REG_SUN_GAIN:      prdata = cfg_reg.sun_gain;
            REG_RATE_THR:      prdata = 32'(cfg_reg.rate_threshold);
            REG_SUN_MIN:       prdata = 32'(cfg_reg.sun_min_magnitude);
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/bsac_alu.sv -----
// Shared bit-serial multiply, divide and square root unit.
`default_nettype none
module bsac_alu (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bsac_pkg::alu_ctl_t            ctl,
    input  wire logic [bsac_pkg::ALU_W-1:0]    opa,
    input  wire logic [bsac_pkg::ALU_W-1:0]    opb,
    output logic                               done,
    output logic      [bsac_pkg::ALU_W-1:0]    result
);
    import bsac_pkg::*;

    logic [ALU_W-1:0] acc_reg, acc_next;
    logic [ALU_W-1:0] a_reg, a_next;
    logic [ALU_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    alu_op_t          op_reg, op_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [ALU_W-1:0] sum;
    logic [ALU_W-1:0] rem_sh;
    logic             rem_ge;
    logic [ALU_W-1:0] trial;
    logic             sq_ge;

    assign sum    = acc_reg + a_reg;
    assign rem_sh = {acc_reg[ALU_W-2:0], a_reg[ALU_W-1]};
    assign rem_ge = rem_sh >= b_reg;
    assign trial  = a_reg + b_reg;
    assign sq_ge  = acc_reg >= trial;

    assign done   = done_reg;
    assign result = (op_reg == OP_MUL) ? acc_reg : a_reg;

    // Load operands on start, else advance one step
    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            op_next   = ctl.op;
            busy_next = 1'b1;
            unique case (ctl.op)
                OP_MUL:
                begin
                    acc_next = '0;
                    a_next   = opa;
                    b_next   = opb;
                    cnt_next = CNT_W'(MUL_STEPS);
                end
                OP_DIV:
                begin
                    acc_next = '0;
                    a_next   = opa;
                    b_next   = opb;
                    cnt_next = CNT_W'(DIV_STEPS);
                end
                OP_SQRT:
                begin
                    acc_next = opa;
                    a_next   = '0;
                    b_next   = SQRT_BIT0;
                    cnt_next = CNT_W'(SQRT_STEPS);
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            unique case (op_reg)
                OP_MUL:
                begin
                    if (b_reg[0])
                        acc_next = sum;
                    a_next = a_reg << 1;
                    b_next = b_reg >> 1;
                end
                OP_DIV:
                begin
                    acc_next = rem_ge ? (rem_sh - b_reg) : rem_sh;
                    a_next   = {a_reg[ALU_W-2:0], rem_ge};
                end
                OP_SQRT:
                begin
                    if (sq_ge)
                    begin
                        acc_next = acc_reg - trial;
                        a_next   = (a_reg >> 1) + b_reg;
                    end
                    else
                        a_next = a_reg >> 1;
                    b_next = b_reg >> 2;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end
endmodule
`default_nettype wire

// ----- rtl/bdot_sunpoint_attitude_control_unit.sv -----
// Top level of the B-dot detumble and sun-pointing attitude control unit.
//
// One request on in_ch carries a control tick: field, sun vector, eclipse flag
// and body rates. One request on out_ch returns the held torque and the mode
// after that tick. The user must write gains and thresholds over the APB port
// only while the unit is idle; the unit itself does not enforce this. pready
// is always high and reads return the registers. The unit takes one tick at a
// time. All products, the square root and the divisions run through one
// bit-serial unit, one bit per cycle. in_ch.ready is high only between ticks;
// a finished result waits in the output register, so the next tick is
// accepted while out_ch stalls, and it completes only once that result is
// taken. Reset clears the mode to detumble, sets the first-sample flag and
// clears stored field and torque.
`default_nettype none
module bdot_sunpoint_attitude_control_unit #(
    parameter int FIELD_WIDTH  = bsac_pkg::FIELD_WIDTH_DEF,
    parameter int TORQUE_WIDTH = bsac_pkg::TORQUE_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    bsac_in_if.sink                              in_ch,
    bsac_out_if.source                           out_ch,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bsac_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);
    import bsac_pkg::*;

    localparam logic [63:0] TQ_LIM = (64'd1 << (TORQUE_WIDTH - 1)) - 64'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        SP_RX, SP_RY, SP_RZ, SP_THR,
        SP_DX, SP_DY, SP_DZ,
        SP_SX, SP_SY, SP_SZ, SP_SMIN, SP_SQRT,
        SP_MX, SP_QX, SP_MY, SP_QY
    } step_t;

    // Saturate a magnitude and sign to the torque width
    function automatic logic [TORQUE_WIDTH-1:0] sat_f(input logic [63:0] mag,
                                                      input logic neg);
        logic [63:0] neg_mag;
        neg_mag = 64'd0 - mag;
        if (neg)
        begin
            if (mag > TQ_LIM + 64'd1)
                return {1'b1, {(TORQUE_WIDTH-1){1'b0}}};
            return neg_mag[TORQUE_WIDTH-1:0];
        end
        if (mag > TQ_LIM)
            return {1'b0, {(TORQUE_WIDTH-1){1'b1}}};
        return mag[TORQUE_WIDTH-1:0];
    endfunction

    cfg_t             cfg;
    alu_ctl_t         alu_ctl;
    logic [ALU_W-1:0] alu_a, alu_b, alu_res;
    logic             alu_done;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;

    logic signed [FIELD_WIDTH-1:0]  f_reg [3];
    logic signed [FIELD_WIDTH-1:0]  f_next [3];
    logic signed [15:0]             s_reg [3];
    logic signed [15:0]             s_next [3];
    logic signed [15:0]             r_reg [3];
    logic signed [15:0]             r_next [3];
    logic                           ecl_reg, ecl_next;
    logic signed [FIELD_WIDTH-1:0]  last_reg [3];
    logic signed [FIELD_WIDTH-1:0]  last_next [3];
    logic [TORQUE_WIDTH-1:0]        held_reg [3];
    logic [TORQUE_WIDTH-1:0]        held_next [3];
    logic                           first_reg, first_next;
    logic                           mode_reg, mode_next;
    logic [31:0]                    rr_reg, rr_next;
    logic [31:0]                    thr2_reg, thr2_next;
    logic [31:0]                    ss_reg, ss_next;
    logic [23:0]                    m_reg, m_next;
    logic [63:0]                    prod_reg, prod_next;

    logic                           out_valid_reg, out_valid_next;
    logic [TORQUE_WIDTH-1:0]        out_tq_reg [3];
    logic [TORQUE_WIDTH-1:0]        out_tq_next [3];
    logic                           out_mode_reg, out_mode_next;

    logic signed [FIELD_WIDTH:0]    d_w [3];
    logic [FIELD_WIDTH:0]           dabs_w [3];
    logic [15:0]                    sabs_w [3];
    logic [15:0]                    rabs_w [3];
    logic                           in_acc;
    logic signed [63:0]             ext_x, ext_y, ext_z;

    bsac_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bsac_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (alu_ctl),
        .opa    (alu_a),
        .opb    (alu_b),
        .done   (alu_done),
        .result (alu_res)
    );

    // Field change and magnitudes per axis
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_w[i]    = (FIELD_WIDTH+1)'(f_reg[i]) - (FIELD_WIDTH+1)'(last_reg[i]);
            dabs_w[i] = d_w[i][FIELD_WIDTH] ? (FIELD_WIDTH+1)'(-d_w[i])
                                            : (FIELD_WIDTH+1)'(d_w[i]);
            sabs_w[i] = s_reg[i][15] ? 16'(-s_reg[i]) : 16'(s_reg[i]);
            rabs_w[i] = r_reg[i][15] ? 16'(-r_reg[i]) : 16'(r_reg[i]);
        end
    end

    // Select operands for the current step
    always_comb
    begin
        alu_ctl.start = (state_reg == ST_ISSUE);
        alu_ctl.op    = OP_MUL;
        alu_a         = '0;
        alu_b         = '0;
        unique case (step_reg)
            SP_RX: begin alu_a = 64'(rabs_w[0]); alu_b = 64'(rabs_w[0]); end
            SP_RY: begin alu_a = 64'(rabs_w[1]); alu_b = 64'(rabs_w[1]); end
            SP_RZ: begin alu_a = 64'(rabs_w[2]); alu_b = 64'(rabs_w[2]); end
            SP_THR:
            begin
                alu_a = 64'(cfg.rate_threshold);
                alu_b = 64'(cfg.rate_threshold);
            end
            SP_DX: begin alu_a = 64'(cfg.detumble_gain); alu_b = 64'(dabs_w[0]); end
            SP_DY: begin alu_a = 64'(cfg.detumble_gain); alu_b = 64'(dabs_w[1]); end
            SP_DZ: begin alu_a = 64'(cfg.detumble_gain); alu_b = 64'(dabs_w[2]); end
            SP_SX: begin alu_a = 64'(sabs_w[0]); alu_b = 64'(sabs_w[0]); end
            SP_SY: begin alu_a = 64'(sabs_w[1]); alu_b = 64'(sabs_w[1]); end
            SP_SZ: begin alu_a = 64'(sabs_w[2]); alu_b = 64'(sabs_w[2]); end
            SP_SMIN:
            begin
                alu_a = 64'(cfg.sun_min_magnitude);
                alu_b = 64'(cfg.sun_min_magnitude);
            end
            SP_SQRT:
            begin
                alu_ctl.op = OP_SQRT;
                alu_a      = 64'(ss_reg) << 16;
            end
            SP_MX: begin alu_a = 64'(cfg.sun_gain); alu_b = 64'(sabs_w[1]); end
            SP_MY: begin alu_a = 64'(cfg.sun_gain); alu_b = 64'(sabs_w[0]); end
            SP_QX, SP_QY:
            begin
                alu_ctl.op = OP_DIV;
                alu_a      = (prod_reg << 8) + 64'(m_reg >> 1);
                alu_b      = 64'(m_reg);
            end
        endcase
    end

    // Sequence the tick through the shared unit
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        f_next         = f_reg;
        s_next         = s_reg;
        r_next         = r_reg;
        ecl_next       = ecl_reg;
        last_next      = last_reg;
        held_next      = held_reg;
        first_next     = first_reg;
        mode_next      = mode_reg;
        rr_next        = rr_reg;
        thr2_next      = thr2_reg;
        ss_next        = ss_reg;
        m_next         = m_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_tq_next    = out_tq_reg;
        out_mode_next  = out_mode_reg;
        in_acc         = in_ch.valid && (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    f_next[0] = FIELD_WIDTH'(in_ch.field_x);
                    f_next[1] = FIELD_WIDTH'(in_ch.field_y);
                    f_next[2] = FIELD_WIDTH'(in_ch.field_z);
                    s_next[0] = in_ch.sun_x;
                    s_next[1] = in_ch.sun_y;
                    s_next[2] = in_ch.sun_z;
                    r_next[0] = in_ch.rate_x;
                    r_next[1] = in_ch.rate_y;
                    r_next[2] = in_ch.rate_z;
                    ecl_next  = in_ch.eclipse;
                    step_next = SP_RX;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (alu_done)
                begin
                    state_next = ST_ISSUE;
                    unique case (step_reg)
                        SP_RX:
                        begin
                            rr_next   = alu_res[31:0];
                            step_next = SP_RY;
                        end
                        SP_RY:
                        begin
                            rr_next   = rr_reg + alu_res[31:0];
                            step_next = SP_RZ;
                        end
                        SP_RZ:
                        begin
                            rr_next   = rr_reg + alu_res[31:0];
                            step_next = SP_THR;
                        end
                        SP_THR:
                        begin
                            thr2_next = alu_res[31:0];
                            if (!mode_reg)
                            begin
                                if (first_reg)
                                begin
                                    // First tick only stores the field and sets the mode
                                    first_next = 1'b0;
                                    last_next  = f_reg;
                                    mode_next  = rr_reg < alu_res[31:0];
                                    state_next = ST_OUT;
                                end
                                else
                                    step_next = SP_DX;
                            end
                            else if (ecl_reg)
                            begin
                                held_next[0] = '0;
                                held_next[1] = '0;
                                held_next[2] = '0;
                                mode_next  = !(34'(rr_reg) > (34'(alu_res[31:0]) << 2));
                                state_next = ST_OUT;
                            end
                            else
                                step_next = SP_SX;
                        end
                        SP_DX:
                        begin
                            held_next[0] = sat_f(alu_res, d_w[0] > 0);
                            step_next    = SP_DY;
                        end
                        SP_DY:
                        begin
                            held_next[1] = sat_f(alu_res, d_w[1] > 0);
                            step_next    = SP_DZ;
                        end
                        SP_DZ:
                        begin
                            held_next[2] = sat_f(alu_res, d_w[2] > 0);
                            last_next    = f_reg;
                            mode_next    = rr_reg < thr2_reg;
                            state_next   = ST_OUT;
                        end
                        SP_SX:
                        begin
                            ss_next   = alu_res[31:0];
                            step_next = SP_SY;
                        end
                        SP_SY:
                        begin
                            ss_next   = ss_reg + alu_res[31:0];
                            step_next = SP_SZ;
                        end
                        SP_SZ:
                        begin
                            ss_next   = ss_reg + alu_res[31:0];
                            step_next = SP_SMIN;
                        end
                        SP_SMIN:
                        begin
                            if (ss_reg != '0 && ss_reg >= alu_res[31:0])
                                step_next = SP_SQRT;
                            else
                            begin
                                // Sun too weak: hold the torque
                                mode_next  = !(34'(rr_reg) > (34'(thr2_reg) << 2));
                                state_next = ST_OUT;
                            end
                        end
                        SP_SQRT:
                        begin
                            m_next    = alu_res[23:0];
                            step_next = SP_MX;
                        end
                        SP_MX:
                        begin
                            prod_next = alu_res;
                            step_next = SP_QX;
                        end
                        SP_QX:
                        begin
                            held_next[0] = sat_f(alu_res, s_reg[1] > 0);
                            step_next    = SP_MY;
                        end
                        SP_MY:
                        begin
                            prod_next = alu_res;
                            step_next = SP_QY;
                        end
                        SP_QY:
                        begin
                            held_next[1] = sat_f(alu_res, s_reg[0] < 0);
                            held_next[2] = '0;
                            mode_next    = !(34'(rr_reg) > (34'(thr2_reg) << 2));
                            state_next   = ST_OUT;
                        end
                    endcase
                end
            end
            ST_OUT:
            begin
                // Load the result once the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_tq_next    = held_reg;
                    out_mode_next  = mode_reg;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= SP_RX;
            first_reg     <= 1'b1;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                last_reg[i] <= '0;
                held_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            first_reg     <= first_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            held_reg      <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg        <= f_next;
        s_reg        <= s_next;
        r_reg        <= r_next;
        ecl_reg      <= ecl_next;
        rr_reg       <= rr_next;
        thr2_reg     <= thr2_next;
        ss_reg       <= ss_next;
        m_reg        <= m_next;
        prod_reg     <= prod_next;
        out_tq_reg   <= out_tq_next;
        out_mode_reg <= out_mode_next;
    end

    // Drive the channels
    assign ext_x = 64'(signed'(out_tq_reg[0]));
    assign ext_y = 64'(signed'(out_tq_reg[1]));
    assign ext_z = 64'(signed'(out_tq_reg[2]));

    assign in_ch.ready     = (state_reg == ST_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.torque_x = ext_x[31:0];
    assign out_ch.torque_y = ext_y[31:0];
    assign out_ch.torque_z = ext_z[31:0];
    assign out_ch.mode_now = out_mode_reg;
endmodule
`default_nettype wire

// ----- rtl/bsac_checker.sv -----
// Port-level checker of the attitude control unit and its bind.
`default_nettype none
`include "bdot_sunpoint_attitude_control_unit_defines.svh"
module bsac_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] torque_x,
    input wire logic        mode_now,
    input wire logic        pready
);
    `BSAC_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready after accept")
    `BSAC_ASSERT_NEXT(a_no_fast_result, in_valid && in_ready, !$rose(out_valid),
                      "result one cycle after accept")
    `BSAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                      out_valid && $stable(torque_x) && $stable(mode_now),
                      "stalled result changed")
    `BSAC_ASSERT_SAME(a_pready_high, 1'b1, pready, "pready low")
endmodule

bind bdot_sunpoint_attitude_control_unit bsac_checker u_bsac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .torque_x  (out_ch.torque_x),
    .mode_now  (out_ch.mode_now),
    .pready    (pready)
);
`default_nettype wire
